// ----- rtl/bobs_pkg.sv -----
// Shared types and constants for the black offset bracket search
package bobs_pkg;

	localparam int OFS_W   = 14;
	localparam int LEVEL_W = 16;
	localparam int INCR_W  = 8;
	localparam int CNT_W   = 2;
	localparam int CFG_W   = 16;
	localparam int ADDR_W  = 3;

	typedef enum logic [ADDR_W-1:0] {
		REG_START  = 3'd0,
		REG_MAX    = 3'd1,
		REG_COUNT  = 3'd2,
		REG_BASE   = 3'd3,
		REG_INCR   = 3'd4,
		REG_STEP   = 3'd5,
		REG_SWAP   = 3'd6
	} reg_idx_t;

	localparam logic [OFS_W-1:0]   START_RST = 14'd2045;
	localparam logic [OFS_W-1:0]   MAX_RST   = 14'd8192;
	localparam logic [CNT_W-1:0]   COUNT_RST = 2'd2;
	localparam logic [LEVEL_W-1:0] BASE_RST  = 16'd1;
	localparam logic [INCR_W-1:0]  INCR_RST  = 8'd1;
	localparam logic [OFS_W-1:0]   STEP_RST  = 14'd16;

	typedef enum logic [1:0] {
		FIN_SEARCH = 2'd0,
		FIN_DONE   = 2'd1,
		FIN_STALL  = 2'd2
	} fin_t;

	typedef struct packed {
		logic [OFS_W-1:0]   start_value;
		logic [OFS_W-1:0]   max_value;
		logic [CNT_W-1:0]   channel_count;
		logic [LEVEL_W-1:0] base_level;
		logic [INCR_W-1:0]  increment;
		logic [OFS_W-1:0]   step_size;
		logic               swap_even_odd;
	} cfg_t;

	typedef struct packed {
		logic [OFS_W-1:0] ofs;
		logic [OFS_W-1:0] lo;
		logic [OFS_W-1:0] hi;
		logic             lo_known;
		logic             hi_known;
	} chan_t;

endpackage

// ----- rtl/black_offset_bracket_search.sv -----
// Top level: black-level offset search over two converter channels
//
//  channel  beat signals           payload
//  in       in_valid / in_ready    func, level_0, level_1
//  out      out_valid / out_ready  offset_0, offset_1, converged, stalled
//  cfg      cfg_we                 cfg_addr, cfg_data
//
// One beat per cycle while in_ready is high; the result is registered and appears in the cycle after its input beat.
// Search state and the result register update together at the input beat.
// in_ready drops only while a held result is not taken.
// Reset loads the register defaults and the start offset of 2045.
module black_offset_bracket_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bobs_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [bobs_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [bobs_pkg::LEVEL_W-1:0]  level_0,
	input  logic [bobs_pkg::LEVEL_W-1:0]  level_1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bobs_pkg::OFS_W-1:0]    offset_0,
	output logic [bobs_pkg::OFS_W-1:0]    offset_1,
	output logic                          converged,
	output logic                          stalled
);

	bobs_pkg::cfg_t  cfg;
	bobs_pkg::chan_t ch0_q, ch1_q, ch0_n, ch1_n, upd0, upd1, restart;
	bobs_pkg::fin_t  fin_q, fin_n;
	logic [bobs_pkg::LEVEL_W-1:0] lev0, lev1;
	logic [bobs_pkg::INCR_W-1:0]  add;
	logic conv0, conv1, chg0, chg1, used2, all_conv, accept;
	logic out_valid_q;
	logic [bobs_pkg::OFS_W-1:0] ofs0_q, ofs1_q;
	logic conv_q, stall_q;

	bobs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign used2 = cfg.channel_count[1];

	always_comb begin
		priority if (!used2) begin
			lev0 = (level_0 < level_1) ? level_0 : level_1;
			lev1 = '0;
		end else if (cfg.swap_even_odd) begin
			lev0 = level_1;
			lev1 = level_0;
		end else begin
			lev0 = level_0;
			lev1 = level_1;
		end
	end

	assign all_conv = conv0 && (conv1 || !used2);
	assign add      = all_conv ? cfg.increment : '0;

	bobs_chan u_ch0 (
		.cur (ch0_q), .level (lev0), .cfg (cfg), .add (add),
		.nxt (upd0), .conv (conv0), .changed (chg0)
	);

	bobs_chan u_ch1 (
		.cur (ch1_q), .level (lev1), .cfg (cfg), .add (add),
		.nxt (upd1), .conv (conv1), .changed (chg1)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		restart.ofs      = cfg.start_value;
		restart.lo       = '0;
		restart.hi       = '0;
		restart.lo_known = 1'b0;
		restart.hi_known = 1'b0;
		ch0_n = ch0_q;
		ch1_n = ch1_q;
		fin_n = fin_q;
		if (func) begin
			ch0_n = restart;
			ch1_n = restart;
			fin_n = bobs_pkg::FIN_SEARCH;
		end else if (fin_q == bobs_pkg::FIN_SEARCH) begin
			ch0_n = upd0;
			if (used2)
				ch1_n = upd1;
			if (all_conv)
				fin_n = bobs_pkg::FIN_DONE;
			else if (!(chg0 || (used2 && chg1)))
				fin_n = bobs_pkg::FIN_STALL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch0_q       <= '{ofs: bobs_pkg::START_RST, lo: '0, hi: '0,
				lo_known: 1'b0, hi_known: 1'b0};
			ch1_q       <= '{ofs: bobs_pkg::START_RST, lo: '0, hi: '0,
				lo_known: 1'b0, hi_known: 1'b0};
			fin_q       <= bobs_pkg::FIN_SEARCH;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				ch0_q <= ch0_n;
				ch1_q <= ch1_n;
				fin_q <= fin_n;
			end
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			ofs0_q  <= ch0_n.ofs;
			ofs1_q  <= ch1_n.ofs;
			conv_q  <= (fin_n == bobs_pkg::FIN_DONE);
			stall_q <= (fin_n == bobs_pkg::FIN_STALL);
		end
	end

	assign out_valid = out_valid_q;
	assign offset_0  = ofs0_q;
	assign offset_1  = ofs1_q;
	assign converged = conv_q;
	assign stalled   = stall_q;

endmodule

// ----- rtl/bobs_cfg.sv -----
// Configuration register file
module bobs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bobs_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [bobs_pkg::CFG_W-1:0]   cfg_data,
	output bobs_pkg::cfg_t               cfg
);

	bobs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_value   <= bobs_pkg::START_RST;
			cfg_q.max_value     <= bobs_pkg::MAX_RST;
			cfg_q.channel_count <= bobs_pkg::COUNT_RST;
			cfg_q.base_level    <= bobs_pkg::BASE_RST;
			cfg_q.increment     <= bobs_pkg::INCR_RST;
			cfg_q.step_size     <= bobs_pkg::STEP_RST;
			cfg_q.swap_even_odd <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bobs_pkg::REG_START: cfg_q.start_value   <= cfg_data[bobs_pkg::OFS_W-1:0];
				bobs_pkg::REG_MAX:   cfg_q.max_value     <= cfg_data[bobs_pkg::OFS_W-1:0];
				bobs_pkg::REG_COUNT: cfg_q.channel_count <= cfg_data[bobs_pkg::CNT_W-1:0];
				bobs_pkg::REG_BASE:  cfg_q.base_level    <= cfg_data;
				bobs_pkg::REG_INCR:  cfg_q.increment     <= cfg_data[bobs_pkg::INCR_W-1:0];
				bobs_pkg::REG_STEP:  cfg_q.step_size     <= cfg_data[bobs_pkg::OFS_W-1:0];
				bobs_pkg::REG_SWAP:  cfg_q.swap_even_odd <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/bobs_chan.sv -----
// One channel's bracket update and clamped next offset
module bobs_chan (
	input  bobs_pkg::chan_t                cur,
	input  logic [bobs_pkg::LEVEL_W-1:0]   level,
	input  bobs_pkg::cfg_t                 cfg,
	input  logic [bobs_pkg::INCR_W-1:0]    add,
	output bobs_pkg::chan_t                nxt,
	output logic                           conv,
	output logic                           changed
);

	localparam int W1 = bobs_pkg::OFS_W + 1;

	logic          is_low;
	logic [W1-1:0] up;
	logic [W1-1:0] step_val;
	logic [W1-1:0] sum;
	logic signed [W1-1:0] diff;
	logic [W1:0]   with_add;
	logic [bobs_pkg::OFS_W-1:0] lo_n, hi_n, clamped;

	always_comb begin
		is_low = (level <= cfg.base_level);
		lo_n   = is_low ? cur.ofs : cur.lo;
		hi_n   = is_low ? cur.hi  : cur.ofs;
		up     = {1'b0, cur.ofs} + {1'b0, cfg.step_size};
		sum    = {1'b0, lo_n} + {1'b0, hi_n};
		diff   = $signed({1'b0, lo_n}) - $signed({1'b0, hi_n});
		conv   = 1'b0;
		priority if (is_low && !cur.hi_known) begin
			step_val = (cur.ofs > cfg.step_size) ?
				{1'b0, cur.ofs - cfg.step_size} : '0;
		end else if (!is_low && !cur.lo_known) begin
			step_val = (up < {1'b0, cfg.max_value}) ? up : {1'b0, cfg.max_value};
		end else if (diff < $signed(W1'(2))) begin
			conv     = 1'b1;
			step_val = {1'b0, (lo_n < hi_n) ? lo_n : hi_n};
		end else begin
			step_val = sum >> 1;
		end
		with_add = {1'b0, step_val} + {{(W1 + 1 - bobs_pkg::INCR_W){1'b0}}, add};
		clamped  = (with_add > {2'b00, cfg.max_value}) ? cfg.max_value
			: with_add[bobs_pkg::OFS_W-1:0];
		changed  = (clamped != cur.ofs);

		nxt.ofs      = clamped;
		nxt.lo       = lo_n;
		nxt.hi       = hi_n;
		nxt.lo_known = cur.lo_known | is_low;
		nxt.hi_known = cur.hi_known | ~is_low;
	end

endmodule

// ----- rtl/bobs_chk.sv -----
// Port-level checker for the offset search, bound to the top level
module bobs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bobs_pkg::OFS_W-1:0]    offset_0,
	input logic                          converged,
	input logic                          stalled
);

	// every input beat leaves a result behind it
	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("input beat without result");

	// empty output side never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(converged && stalled))
		else $error("converged and stalled together");

	// a restart always reopens the search
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func |=> !converged && !stalled)
		else $error("restart left a flag set");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(offset_0))
		else $error("held result changed");

endmodule

bind black_offset_bracket_search bobs_chk u_bobs_chk (.*);
